>>> rtl/cprm_pkg.sv
// ---------------------------------------------------------------------------
// cprm_pkg: shared types and constants of the cartridge page-remap mapper
// Item kinds, register codes, queue item and result layouts, reset values.
// ---------------------------------------------------------------------------
package cprm_pkg;

    localparam int PAGE_COUNT = 16;
    localparam int PAGE_IDX_W = 4;
    localparam int PAGE_OFF_W = 9;
    localparam int PHYS_W     = 27;
    localparam int SRC_W      = 26;
    localparam int DST_W      = 23;

    localparam logic [31:0]       WIN_MASK    = 32'h01FF_FF00;
    localparam logic [31:0]       WIN_MATCH   = 32'h0080_0100;
    localparam logic [31:0]       ALIGN_MASK  = 32'hFFFF_E1FF;
    localparam logic [31:0]       CMD_MAP     = 32'h0000_0001;
    localparam logic [31:0]       CMD_MAP_ALT = 32'h0000_0011;
    localparam logic [SRC_W-1:0]  SRC_RESET   = 26'h000_0200;
    localparam logic [DST_W-1:0]  DST_RESET   = 23'h00_1000;
    localparam logic [31:0]       LEN_RESET   = 32'h0000_1000;
    localparam logic [PHYS_W-1:0] PEAK_RESET  = 27'h000_1200;
    localparam logic [PHYS_W-1:0] ROM_RESET   = 27'h400_0000;

    // Raw item kinds on the input port
    localparam logic [1:0] CMD_WR16  = 2'd0;
    localparam logic [1:0] CMD_WR32  = 2'd1;
    localparam logic [1:0] CMD_XLATE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_ROM    = 1'b1;

    typedef enum logic [1:0] {
        K_NOP,
        K_WR16,
        K_WR32,
        K_XLATE
    } t_kind;

    typedef enum logic [1:0] {
        R_CMD,
        R_SRC,
        R_DST,
        R_LEN
    } t_reg;

    typedef struct packed {
        t_kind       kind;
        t_reg        rsel;
        logic [31:0] data;
        logic [25:0] offset;
        logic [2:0]  width;
    } t_item;

    typedef struct packed {
        logic [PHYS_W-1:0] phys;
        logic              ok;
        logic              done;
        logic [31:0]       total;
        logic [PHYS_W-1:0] peak;
    } t_result;

    // Power-on layout: low half identity, upper half shifted by one page
    function automatic logic [PHYS_W-1:0] page_reset(input logic [PAGE_IDX_W-1:0] idx);
        logic [PHYS_W-1:0] base;
        base = {{(PHYS_W-PAGE_IDX_W+1){1'b0}}, idx[PAGE_IDX_W-2:0]} << PAGE_OFF_W;
        if (idx[PAGE_IDX_W-1]) begin
            return base + PHYS_W'(32'h200);
        end
        return base;
    endfunction

endpackage

>>> rtl/cprm_front.sv
// ---------------------------------------------------------------------------
// cprm_front: input classifier
// Decode the register window and sort items into writes, translates and
// no-ops before they enter the queue.
// ---------------------------------------------------------------------------
module cprm_front
    import cprm_pkg::*;
(
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_bus_address,
    input  logic [31:0] i_write_data,
    input  logic [25:0] i_cart_offset,
    input  logic [2:0]  i_access_bytes,
    input  logic        i_enabled,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    logic win_hit;

    // Window hit and one of the four decoded register slots
    assign win_hit = ((i_bus_address & WIN_MASK) == WIN_MATCH) && (i_bus_address[5:4] == 2'b00);

    always_comb begin
        o_item.rsel   = t_reg'(i_bus_address[3:2]);
        o_item.data   = i_write_data;
        o_item.offset = i_cart_offset;
        o_item.width  = i_access_bytes;
        case (i_cmd)
            CMD_XLATE: o_item.kind = K_XLATE;
            CMD_WR16:  o_item.kind = (i_enabled && win_hit) ? K_WR16 : K_NOP;
            CMD_WR32:  o_item.kind = (i_enabled && win_hit) ? K_WR32 : K_NOP;
            default:   o_item.kind = K_NOP;
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

>>> rtl/cprm_queue.sv
// ---------------------------------------------------------------------------
// cprm_queue: item queue between classifier and executor
// Small circular buffer; lets each side stall on its own.
// ---------------------------------------------------------------------------
module cprm_queue
    import cprm_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/cprm_back.sv
// ---------------------------------------------------------------------------
// cprm_back: mapper executor
// Hold mapper registers and page table, run remaps one page a cycle,
// translate offsets and drive the result register.
// ---------------------------------------------------------------------------
module cprm_back
    import cprm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_enabled,
    input  logic [PHYS_W-1:0] i_rom_bytes,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_REMAP
    } t_state;

    t_state            r_state;
    logic [31:0]       r_command;
    logic [SRC_W-1:0]  r_src;
    logic [DST_W-1:0]  r_dst;
    logic [31:0]       r_len;
    logic [PHYS_W-1:0] r_table [PAGE_COUNT];
    logic [31:0]       r_total;
    logic [PHYS_W-1:0] r_peak;
    logic [PHYS_W-1:0] r_phys;
    logic [2:0]        r_width;
    logic [PAGE_IDX_W-1:0] r_page;
    logic [PAGE_IDX_W-1:0] r_left;
    logic [PHYS_W-1:0] r_map_addr;
    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              pop;
    logic [31:0]       prev;
    logic [31:0]       merged;
    logic              remap_ok;
    logic              is_map;
    logic              is_write;
    logic              remap_go;
    logic              set_out;
    logic [PHYS_W-1:0] phys_end;
    logic [PHYS_W-1:0] xlate_phys;
    logic [PHYS_W-1:0] rom_left;
    logic              xlate_ok;

    assign out_free = !r_out_valid || i_ready;
    assign pop      = (r_state == S_IDLE) && i_q_valid && out_free;
    assign o_pop    = pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        case (i_q_item.rsel)
            R_CMD:   prev = r_command;
            R_SRC:   prev = {{(32-SRC_W){1'b0}}, r_src};
            R_DST:   prev = {{(32-DST_W){1'b0}}, r_dst};
            R_LEN:   prev = r_len;
            default: prev = '0;
        endcase
        merged = (i_q_item.kind == K_WR32) ? i_q_item.data
                                           : {prev[31:16], i_q_item.data[15:0]};
    end

    // Aligned destination and size, non-zero size, run ends inside the aperture
    assign remap_ok = (({{(32-DST_W){1'b0}}, r_dst} & ALIGN_MASK) == '0)
                   && ((r_len & ALIGN_MASK) == '0)
                   && (r_len[12:9] != '0)
                   && (({1'b0, r_dst[12:9]} + {1'b0, r_len[12:9]}) <= 5'd16);
    assign is_map   = (merged == CMD_MAP) || (merged == CMD_MAP_ALT);
    assign phys_end = {1'b0, r_src} + {{(PHYS_W-13){1'b0}}, r_len[12:0]};
    assign is_write = (i_q_item.kind == K_WR16) || (i_q_item.kind == K_WR32);
    assign remap_go = pop && is_write && (i_q_item.rsel == R_CMD) && is_map && remap_ok;

    // Present a result for a popped write or no-op, or once the bounds check is done
    assign set_out  = (pop && (i_q_item.kind != K_XLATE)) || ((r_state == S_CHECK) && out_free);

    assign xlate_phys = (i_enabled && (i_q_item.offset[25:13] == '0))
        ? r_table[i_q_item.offset[12:9]]
          + {{(PHYS_W-PAGE_OFF_W){1'b0}}, i_q_item.offset[PAGE_OFF_W-1:0]}
        : {1'b0, i_q_item.offset};

    assign rom_left = i_rom_bytes - r_phys;
    assign xlate_ok = (r_width != '0) && (r_phys <= i_rom_bytes)
                   && ({{(PHYS_W-3){1'b0}}, r_width} <= rom_left);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_command   <= '0;
            r_src       <= SRC_RESET;
            r_dst       <= DST_RESET;
            r_len       <= LEN_RESET;
            r_total     <= '0;
            r_peak      <= PEAK_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PAGE_COUNT; i++) begin
                r_table[i] <= page_reset(PAGE_IDX_W'(i));
            end
        end else begin
            if (set_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_out.phys  <= '0;
                        r_out.ok    <= 1'b0;
                        r_out.done  <= remap_go;
                        r_out.total <= remap_go ? r_total + 32'd1 : r_total;
                        r_out.peak  <= (remap_go && (phys_end > r_peak)) ? phys_end : r_peak;
                        if (i_q_item.kind == K_XLATE) begin
                            // Hold the lookup; bounds check next cycle
                            r_phys  <= xlate_phys;
                            r_width <= i_q_item.width;
                            r_state <= S_CHECK;
                        end else if (is_write) begin
                            case (i_q_item.rsel)
                                R_CMD: begin
                                    r_command <= merged;
                                    if (remap_go) begin
                                        r_total <= r_total + 32'd1;
                                        if (phys_end > r_peak) begin
                                            r_peak <= phys_end;
                                        end
                                        r_page     <= r_dst[12:9];
                                        r_left     <= r_len[12:9];
                                        r_map_addr <= {1'b0, r_src};
                                        r_state    <= S_REMAP;
                                    end
                                end
                                R_SRC: r_src <= merged[SRC_W-1:0];
                                R_DST: r_dst <= merged[DST_W-1:0];
                                R_LEN: begin
                                    if (merged != '0) begin
                                        r_len <= {merged[22:0], 9'b0};
                                    end
                                end
                                default: r_command <= r_command;
                            endcase
                        end
                    end
                end
                S_CHECK: begin
                    if (out_free) begin
                        r_out.phys  <= xlate_ok ? r_phys : '0;
                        r_out.ok    <= xlate_ok;
                        r_state     <= S_IDLE;
                    end
                end
                S_REMAP: begin
                    // Write one page entry a cycle
                    r_table[r_page] <= r_map_addr;
                    r_page          <= r_page + 1'b1;
                    r_map_addr      <= r_map_addr + PHYS_W'(32'h200);
                    r_left          <= r_left - 1'b1;
                    if (r_left == PAGE_IDX_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/cart_page_remap_mapper.sv
// ---------------------------------------------------------------------------
// cart_page_remap_mapper: cartridge ROM page-remap mapper
// Register writes program a 16-entry page table; translate transactions map
// cart offsets to physical ROM offsets with a ROM bounds check.
// ---------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one transaction per item: a 16-bit
// or 32-bit register write, or a translate. Output channel (o_valid / i_ready)
// returns exactly one result per input transaction, in order. Configuration
// (enable, ROM size) is written on i_cfg_we only while the block is idle; the
// user is bound to this, the block does not enforce it. A translate takes a
// table lookup, then a bounds check. Writes sustain one per cycle while the
// receiver is ready and no remap runs; an accepted remap holds the executor
// while N pages (at most 15) are rewritten one entry a cycle through the
// single table write port.
// A QUEUE_DEPTH queue between classifier and executor keeps input flowing
// while the executor is busy, until the queue fills.
// Reset: synchronous, active low; load the power-on page layout, clear the
// remap count and disable the mapper. A stalled receiver holds the result
// register; the executor then stops and the queue backs up.
// ---------------------------------------------------------------------------
module cart_page_remap_mapper
    import cprm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [PHYS_W-1:0] i_cfg_data,
    // input transactions
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [31:0]       i_bus_address,
    input  logic [31:0]       i_write_data,
    input  logic [25:0]       i_cart_offset,
    input  logic [2:0]        i_access_bytes,
    // result transactions
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PHYS_W-1:0] o_rom_offset,
    output logic              o_translate_ok,
    output logic              o_remap_done,
    output logic [31:0]       o_remap_total,
    output logic [PHYS_W-1:0] o_highest_mapped_end
);

    logic              r_enabled;
    logic [PHYS_W-1:0] r_rom_bytes;

    logic    push;
    t_item   push_item;
    logic    q_full;
    logic    q_valid;
    t_item   q_item;
    logic    q_pop;
    t_result result;

    // Configuration registers: plain writes, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_rom_bytes <= ROM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_enabled   <= i_cfg_data[0];
                CFG_ROM:    r_rom_bytes <= i_cfg_data;
                default:    r_enabled   <= r_enabled;
            endcase
        end
    end

    // Classify and decode each incoming transaction
    cprm_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_bus_address  (i_bus_address),
        .i_write_data   (i_write_data),
        .i_cart_offset  (i_cart_offset),
        .i_access_bytes (i_access_bytes),
        .i_enabled      (r_enabled),
        .i_full         (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    // Decouple the classifier from the executor
    cprm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Execute writes, remaps and translates in order
    cprm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enabled   (r_enabled),
        .i_rom_bytes (r_rom_bytes),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (result)
    );

    assign o_rom_offset         = result.phys;
    assign o_translate_ok       = result.ok;
    assign o_remap_done         = result.done;
    assign o_remap_total        = result.total;
    assign o_highest_mapped_end = result.peak;

endmodule

>>> tb/tb_cart_page_remap_mapper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cart_page_remap_mapper: self-checking bench for the cartridge page mapper
// A directed table covers the power-on layout, the ROM bounds, the register
// window decode and the rejected remap cases. Randomised remap sequences,
// translates and bus noise follow under three idling profiles. Every result
// is compared field by field against a hand-written expectation or a
// page-table predictor kept in step at each accepted transaction.
// ---------------------------------------------------------------------------
module tb_cart_page_remap_mapper;
    import cprm_pkg::*;

    localparam int          STALL_LIMIT  = 2000;  // cycles with no progress
    localparam int          DRAIN_CYCLES = 12;    // extra cycles after the last result has returned
    localparam int          SEG_ITEMS    = 140;
    localparam int          TX_IDLE [3]  = '{22, 50, 0};
    localparam int          RX_IDLE [3]  = '{50, 22, 0};
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [31:0] UNDECODED_OFF = 32'h0000_0010;
    localparam logic [31:0] OUTSIDE_ADDR  = 32'h0080_0000;

    typedef struct {
        bit          cfg;       // reprogram the mapper instead of sending
        bit          cfg_en;
        logic [26:0] cfg_rom;
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] data;
        logic [25:0] off;
        logic [2:0]  width;
        bit          typed;     // res holds the hand-written expectation
        t_result     res;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [PHYS_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_cmd;
    logic [31:0]       i_bus_address;
    logic [31:0]       i_write_data;
    logic [25:0]       i_cart_offset;
    logic [2:0]        i_access_bytes;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [PHYS_W-1:0] o_rom_offset;
    logic              o_translate_ok;
    logic              o_remap_done;
    logic [31:0]       o_remap_total;
    logic [PHYS_W-1:0] o_highest_mapped_end;

    // Predictor state: configuration and the mapper's own registers
    bit          mp_enabled;
    logic [26:0] mp_rom;
    logic [31:0] cmd_word;
    logic [25:0] src_addr;
    logic [22:0] dst_addr;
    logic [31:0] len_bytes;
    logic [26:0] page_tab [PAGE_COUNT];
    logic [31:0] remap_count;
    logic [26:0] peak_end;

    t_result  responses_due [$];
    t_dir_row dir_rows [$];
    int       fail_count  = 0;
    int       items_sent  = 0;
    int       quiet_cycles = 0;
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;

    cart_page_remap_mapper dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_cmd                (i_cmd),
        .i_bus_address        (i_bus_address),
        .i_write_data         (i_write_data),
        .i_cart_offset        (i_cart_offset),
        .i_access_bytes       (i_access_bytes),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_rom_offset         (o_rom_offset),
        .o_translate_ok       (o_translate_ok),
        .o_remap_done         (o_remap_done),
        .o_remap_total        (o_remap_total),
        .o_highest_mapped_end (o_highest_mapped_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Load the power-on layout: lower eight pages identity, upper eight
    // shifted up by one page.
    task automatic reset_mapper_model();
        mp_enabled  = 1'b0;
        mp_rom      = ROM_RESET;
        cmd_word    = '0;
        src_addr    = SRC_RESET;
        dst_addr    = DST_RESET;
        len_bytes   = LEN_RESET;
        remap_count = '0;
        peak_end    = PEAK_RESET;
        for (int i = 0; i < PAGE_COUNT; i++) begin
            page_tab[i] = (i < 8) ? 27'(i * 512) : 27'(32'h200 + (i - 8) * 512);
        end
    endtask

    // Rewrite a run of pages when destination and size are page aligned and
    // the run stays inside the 8 KiB aperture.
    function automatic bit try_remap();
        logic [32:0] last_byte;
        logic [32:0] phys_end;
        logic [3:0]  first_page;
        int          n_pages;
        if (({9'd0, dst_addr} & ALIGN_MASK) != '0 || (len_bytes & ALIGN_MASK) != '0 ||
            len_bytes == '0) begin
            return 1'b0;
        end
        last_byte = 33'(dst_addr) + 33'(len_bytes) - 33'd1;
        if (last_byte[32:13] != '0) begin
            return 1'b0;
        end
        first_page = dst_addr[12:9];
        n_pages    = int'(len_bytes[12:9]);
        for (int i = 0; i < n_pages; i++) begin
            page_tab[4'(first_page + i)] = 27'(32'(src_addr) + 32'(i) * 32'd512);
        end
        phys_end = 33'(src_addr) + 33'(len_bytes);
        if (phys_end > 33'(peak_end)) begin
            peak_end = phys_end[26:0];
        end
        return 1'b1;
    endfunction

    function automatic bit write_reg(input t_reg rsel, input logic [31:0] value);
        case (rsel)
            R_CMD: begin
                cmd_word = value;
                if (value == CMD_MAP || value == CMD_MAP_ALT) begin
                    if (try_remap()) begin
                        remap_count = remap_count + 32'd1;
                        return 1'b1;
                    end
                end
            end
            R_SRC: src_addr = value[25:0];
            R_DST: dst_addr = value[22:0];
            default: begin
                // a zero size leaves the register as it was
                if (value != '0) begin
                    len_bytes = value << 9;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // Work out the result of one accepted transaction and advance the state.
    task automatic mapper_response(input logic [1:0] kind, input logic [31:0] addr,
                                   input logic [31:0] data, input logic [25:0] off,
                                   input logic [2:0] width, output t_result r);
        logic [31:0] phys;
        logic [31:0] prev;
        t_reg        rsel;
        r = '0;
        if (kind == CMD_XLATE) begin
            phys = 32'(off);
            if (mp_enabled && off < 26'h2000) begin
                phys = 32'(page_tab[off[12:9]]) + 32'(off[8:0]);
            end
            if (width != '0 && phys <= 32'(mp_rom) && 32'(width) <= 32'(mp_rom) - phys) begin
                r.phys = phys[26:0];
                r.ok   = 1'b1;
            end
        end else if ((kind == CMD_WR16 || kind == CMD_WR32) && mp_enabled &&
                     (addr & WIN_MASK) == WIN_MATCH && addr[5:4] == 2'b00) begin
            rsel = t_reg'(addr[3:2]);
            if (kind == CMD_WR32) begin
                r.done = write_reg(rsel, data);
            end else begin
                // 16-bit write: merge with the upper half already stored
                case (rsel)
                    R_CMD:   prev = cmd_word;
                    R_SRC:   prev = 32'(src_addr);
                    R_DST:   prev = 32'(dst_addr);
                    default: prev = len_bytes;
                endcase
                r.done = write_reg(rsel, {prev[31:16], data[15:0]});
            end
        end
        r.total = remap_count;
        r.peak  = peak_end;
    endtask

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------

    // Address of a decoded register; noise fills the bits the window ignores.
    function automatic logic [31:0] reg_address(input t_reg rsel, input bit noisy);
        logic [31:0] addr;
        addr = WIN_MATCH | (32'(rsel) << 2);
        if (noisy) begin
            addr = addr | (32'($urandom()) & ~WIN_MASK & ~32'h0000_003C);
        end
        return addr;
    endfunction

    // Present one transaction, hold it until accepted, then predict its result.
    task automatic send_txn(input logic [1:0] kind, input logic [31:0] addr,
                            input logic [31:0] data, input logic [25:0] off,
                            input logic [2:0] width, output t_result due);
        // idle the sender at random, at the profile's rate
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= kind;
        i_bus_address  <= addr;
        i_write_data   <= data;
        i_cart_offset  <= off;
        i_access_bytes <= width;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        mapper_response(kind, addr, data, off, width, due);
    endtask

    task automatic issue(input logic [1:0] kind, input logic [31:0] addr,
                         input logic [31:0] data, input logic [25:0] off,
                         input logic [2:0] width);
        t_result due;
        send_txn(kind, addr, data, off, width, due);
        responses_due.push_back(due);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding result has returned.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (responses_due.size() != 0);
    endtask

    // Write both configuration registers; only called with the block idle.
    task automatic set_mapper(input bit en, input logic [26:0] rom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ENABLE;
        i_cfg_data <= 27'(en);
        @(posedge i_clk);
        mp_enabled = en;
        i_cfg_idx  <= CFG_ROM;
        i_cfg_data <= rom;
        @(posedge i_clk);
        mp_rom = rom;
        i_cfg_we <= 1'b0;
    endtask

    // Random register write, 16 or 32 bits wide; unused fields carry noise.
    task automatic program_reg(input t_reg rsel, input logic [31:0] value);
        if ($urandom_range(9) < 3) begin
            issue(CMD_WR16, reg_address(rsel, 1'b1), {16'($urandom()), value[15:0]},
                  26'($urandom()), 3'($urandom_range(0, 4)));
        end else begin
            issue(CMD_WR32, reg_address(rsel, 1'b1), value,
                  26'($urandom()), 3'($urandom_range(0, 4)));
        end
    endtask

    task automatic translate_burst();
        int unsigned sel;
        logic [25:0] off;
        repeat ($urandom_range(1, 4)) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                off = 26'($urandom_range(0, 32'h1FFF));
            end else if (sel < 75) begin
                // straddle the end of the ROM image
                off = 26'(32'(mp_rom) - $urandom_range(0, 5));
            end else if (sel < 90) begin
                off = 26'($urandom());
            end else begin
                off = 26'(32'h1FF0 + $urandom_range(0, 31));
            end
            issue(CMD_XLATE, $urandom(), $urandom(), off, 3'($urandom_range(0, 4)));
        end
    endtask

    // Program source, destination and size, then issue a map command. Most
    // runs are well formed; a few break alignment, size or the command code.
    task automatic remap_burst();
        int unsigned first;
        int unsigned pages;
        int unsigned sel;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] len;
        logic [31:0] op;
        first = $urandom_range(0, 15);
        pages = $urandom_range(1, 15);
        if ($urandom_range(9) != 0 && first + pages > 16) begin
            pages = 16 - first;
        end
        sel = $urandom_range(9);
        if (sel < 5) begin
            src = $urandom_range(0, 32'h3FFFF);
        end else if (sel < 8) begin
            src = 32'(mp_rom) - $urandom_range(0, 32'h2000);
        end else begin
            src = $urandom();
        end
        dst = first * 512;
        if ($urandom_range(19) == 0) begin
            dst = dst | $urandom_range(1, 511);
        end else if ($urandom_range(19) == 0) begin
            dst = dst | (32'($urandom()) << 13);
        end
        len = pages;
        if ($urandom_range(19) == 0) begin
            len = '0;
        end else if ($urandom_range(29) == 0) begin
            len = $urandom();
        end
        op = $urandom_range(1) ? CMD_MAP : CMD_MAP_ALT;
        if ($urandom_range(14) == 0) begin
            op = $urandom_range(0, 32'h1F);
        end
        if ($urandom_range(7) != 0) program_reg(R_SRC, src);
        if ($urandom_range(7) != 0) program_reg(R_DST, dst);
        if ($urandom_range(7) != 0) program_reg(R_LEN, len);
        program_reg(R_CMD, op);
        translate_burst();
    endtask

    task automatic noise_item();
        logic [31:0] addr;
        addr = $urandom();
        if ($urandom_range(1)) begin
            addr = (addr & ~WIN_MASK) | WIN_MATCH;
        end
        issue(2'($urandom_range(0, 3)), addr, $urandom(), 26'($urandom()),
              3'($urandom_range(0, 4)));
    endtask

    // -----------------------------------------------------------------------
    // Directed table
    // -----------------------------------------------------------------------

    function automatic t_dir_row dir_txn(input logic [1:0] kind, input logic [31:0] addr,
                                         input logic [31:0] data, input logic [25:0] off,
                                         input logic [2:0] width);
        t_dir_row row;
        row       = '{default: '0};
        row.kind  = kind;
        row.addr  = addr;
        row.data  = data;
        row.off   = off;
        row.width = width;
        return row;
    endfunction

    function automatic t_dir_row dir_cfg(input bit en, input logic [26:0] rom);
        t_dir_row row;
        row         = '{default: '0};
        row.cfg     = 1'b1;
        row.cfg_en  = en;
        row.cfg_rom = rom;
        return row;
    endfunction

    function automatic t_dir_row with_result(input t_dir_row row, input logic [26:0] phys,
                                             input logic ok, input logic done,
                                             input logic [31:0] total,
                                             input logic [26:0] peak);
        row.typed = 1'b1;
        row.res   = '{phys, ok, done, total, peak};
        return row;
    endfunction

    task automatic build_directed();
        // mapper disabled after reset: translates pass straight through
        dir_rows.push_back(with_result(dir_txn(CMD_XLATE, '0, '0, 26'h0, 3'd4),
                                       27'h0, 1'b1, 1'b0, 32'd0, PEAK_RESET));
        dir_rows.push_back(with_result(dir_txn(CMD_XLATE, '0, '0, 26'h3FF_FFFF, 3'd4),
                                       27'h0, 1'b0, 1'b0, 32'd0, PEAK_RESET));
        dir_rows.push_back(with_result(dir_txn(CMD_XLATE, '0, '0, 26'h3FF_FFFC, 3'd4),
                                       27'h3FF_FFFC, 1'b1, 1'b0, 32'd0, PEAK_RESET));
        dir_rows.push_back(with_result(dir_txn(CMD_XLATE, '0, '0, 26'h100, 3'd0),
                                       27'h0, 1'b0, 1'b0, 32'd0, PEAK_RESET));
        dir_rows.push_back(with_result(dir_txn(CMD_WR32, reg_address(R_CMD, 1'b0), CMD_MAP,
                                               '0, '0),
                                       27'h0, 1'b0, 1'b0, 32'd0, PEAK_RESET));
        dir_rows.push_back(dir_cfg(1'b1, ROM_RESET));
        // upper half of the aperture starts one page up
        dir_rows.push_back(with_result(dir_txn(CMD_XLATE, '0, '0, 26'h1000, 3'd1),
                                       27'h200, 1'b1, 1'b0, 32'd0, PEAK_RESET));
        dir_rows.push_back(with_result(dir_txn(CMD_XLATE, '0, '0, 26'h2000, 3'd2),
                                       27'h2000, 1'b1, 1'b0, 32'd0, PEAK_RESET));
        // remap with the power-on registers succeeds and leaves the peak alone
        dir_rows.push_back(with_result(dir_txn(CMD_WR32, reg_address(R_CMD, 1'b0), CMD_MAP,
                                               '0, '0),
                                       27'h0, 1'b0, 1'b1, 32'd1, PEAK_RESET));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_SRC, 1'b0), 32'hFFFF_FFFF, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_DST, 1'b0), 32'h0, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR16, reg_address(R_LEN, 1'b0), 32'hABCD_0001, '0, '0));
        // half-width command merges to the alternate map code; peak jumps
        dir_rows.push_back(dir_txn(CMD_WR16, reg_address(R_CMD, 1'b0), 32'h55AA_0011, '0, '0));
        dir_rows.push_back(dir_txn(CMD_XLATE, '0, '0, 26'h1FF, 3'd1));
        dir_rows.push_back(dir_txn(CMD_XLATE, '0, '0, 26'h0, 3'd1));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_LEN, 1'b0), 32'h0, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_DST, 1'b0), 32'hFFFF_FFFF, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_CMD, 1'b0), CMD_MAP, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_DST, 1'b0), 32'h1E00, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_LEN, 1'b0), 32'h2, '0, '0));
        // run would pass the aperture end
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_CMD, 1'b0), CMD_MAP_ALT, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, WIN_MATCH | UNDECODED_OFF, CMD_MAP, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_CMD, 1'b0), 32'h2, '0, '0));
        dir_rows.push_back(dir_txn(CMD_UNUSED, reg_address(R_CMD, 1'b0), CMD_MAP, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, OUTSIDE_ADDR, CMD_MAP, '0, '0));
        dir_rows.push_back(dir_txn(CMD_WR32, reg_address(R_LEN, 1'b0), 32'hFFFF_FFFF, '0, '0));
        // empty ROM: nothing can translate
        dir_rows.push_back(dir_cfg(1'b1, 27'h0));
        dir_rows.push_back(dir_txn(CMD_XLATE, '0, '0, 26'h2000, 3'd1));
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        t_result     due;
        int unsigned sel;
        int          seg_end;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_ENABLE;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_WR16;
        i_bus_address  <= '0;
        i_write_data   <= '0;
        i_cart_offset  <= '0;
        i_access_bytes <= '0;
        reset_mapper_model();
        build_directed();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = TX_IDLE[0];
        rx_idle_pct = RX_IDLE[0];
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg) begin
                wait_drained();
                set_mapper(dir_rows[r].cfg_en, dir_rows[r].cfg_rom);
            end else begin
                send_txn(dir_rows[r].kind, dir_rows[r].addr, dir_rows[r].data,
                         dir_rows[r].off, dir_rows[r].width, due);
                responses_due.push_back(dir_rows[r].typed ? dir_rows[r].res : due);
                items_sent++;
            end
        end

        // Three idling profiles, each through four mapper settings
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = TX_IDLE[ph];
            rx_idle_pct = RX_IDLE[ph];
            for (int seg = 0; seg < 4; seg++) begin
                wait_drained();
                case (seg)
                    0: set_mapper(1'b1, ROM_RESET);
                    1: set_mapper(1'b1, 27'($urandom_range(32'h100, 32'h4_0000)));
                    2: set_mapper(1'b0, 27'($urandom_range(0, 32'h400_0000)));
                    default: set_mapper(1'b1, (ph == 0) ? 27'h0
                                                        : 27'($urandom_range(0, 32'h400_0000)));
                endcase
                seg_end = items_sent + SEG_ITEMS;
                while (items_sent < seg_end) begin
                    // occasionally hold off until the mapper has emptied
                    if ($urandom_range(99) == 0) begin
                        wait_drained();
                    end
                    sel = $urandom_range(99);
                    if (sel < 45) begin
                        remap_burst();
                    end else if (sel < 85) begin
                        translate_burst();
                    end else begin
                        noise_item();
                    end
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_cart_page_remap_mapper OK");
        end else begin
            $display("tb_cart_page_remap_mapper NOT OK");
        end
        $finish;
    end

    // -----------------------------------------------------------------------
    // Receiver, checker and watchdog
    // -----------------------------------------------------------------------

    // Stall the result channel at the current profile's rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each returned transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (responses_due.size() == 0) begin
                $display("%0t: unexpected result expected none actual phys %h ok %b total %h",
                         $time, o_rom_offset, o_translate_ok, o_remap_total);
                fail_count++;
            end else begin
                want = responses_due.pop_front();
                check_field("rom_offset", 32'(want.phys), 32'(o_rom_offset));
                check_field("translate_ok", 32'(want.ok), 32'(o_translate_ok));
                check_field("remap_done", 32'(want.done), 32'(o_remap_done));
                check_field("remap_total", want.total, o_remap_total);
                check_field("highest_mapped_end", 32'(want.peak), 32'(o_highest_mapped_end));
            end
        end
    end

    // Count cycles with work pending but no transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (!i_valid && responses_due.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("tb_cart_page_remap_mapper NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
